// ===== design/dssq_pkg.sv =====
// ----------------------------------------------------------------------------
// dssq_pkg
// Shared types, constants and helpers of the depth-sorted sprite queue.
// ----------------------------------------------------------------------------
package dssq_pkg;

  localparam int unsigned DSSQ_DEPTH = 64;

  localparam int unsigned POS_W   = 20;
  localparam int unsigned LAYER_W = 8;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned KEY_W   = POS_W + LAYER_W;

  // Item opcodes
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // One queued sprite
  typedef struct packed {
    logic signed [POS_W-1:0]   depth;
    logic        [LAYER_W-1:0] layer;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic        [SIZE_W-1:0]  w;
    logic        [SIZE_W-1:0]  h;
    logic        [TAG_W-1:0]   tag;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;
    logic drop;
    logic rd;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic rd_last;
    logic emit_last;
  } sts_t;

  // Unsigned sort key: depth with its sign flipped, then layer
  function automatic logic [KEY_W-1:0] sort_key(input entry_t e);
    sort_key = {~e.depth[POS_W-1], e.depth[POS_W-2:0], e.layer};
  endfunction

endpackage

// ===== design/dssq_ctl.sv =====
// ----------------------------------------------------------------------------
// dssq_ctl
// Sequencer: takes submits in idle, runs one scan of the queue per emitted
// sprite during a flush.
// ----------------------------------------------------------------------------
module dssq_ctl import dssq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic opcode_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  // Decode state into commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_SUBMIT) begin
            cmd_o.wr   = !sts_i.full;
            cmd_o.drop = sts_i.full;
          end else if (!sts_i.empty) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.rd_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.emit_last ? ST_IDLE : ST_SCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== design/dssq_dp.sv =====
// ----------------------------------------------------------------------------
// dssq_dp
// Datapath: entry memory, fill count, minimum search over the queue and the
// result register.
// ----------------------------------------------------------------------------
module dssq_dp import dssq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DSSQ_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic signed [POS_W-1:0]   sort_depth_i,
  input  logic        [LAYER_W-1:0] layer_i,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_y_i,
  input  logic        [SIZE_W-1:0]  dest_width_i,
  input  logic        [SIZE_W-1:0]  dest_height_i,
  input  logic        [SIZE_W-1:0]  src_width_i,
  input  logic        [SIZE_W-1:0]  src_height_i,
  input  logic        [TAG_W-1:0]   attr_tag_i,
  output logic                      out_valid_o,
  output logic signed [POS_W-1:0]   out_x_o,
  output logic signed [POS_W-1:0]   out_y_o,
  output logic        [SIZE_W-1:0]  out_width_o,
  output logic        [SIZE_W-1:0]  out_height_o,
  output logic        [TAG_W-1:0]   out_tag_o,
  output logic                      last_one_o,
  output logic                      dropped_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];

  logic [CW-1:0]          cnt_q, emit_cnt_q;
  logic [AW-1:0]          rd_idx_q, ridx_q, best_idx_q;
  logic                   rd_vld_q, best_vld_q;
  entry_t                 rdata_q, best_q, wr_entry;
  logic [QUEUE_DEPTH-1:0] done_q;
  logic                   take;
  logic                   out_valid_q, last_q, dropped_q;
  entry_t                 out_q;

  // Resolve sizes on the way in
  always_comb begin
    wr_entry.depth = sort_depth_i;
    wr_entry.layer = layer_i;
    wr_entry.x     = pos_x_i;
    wr_entry.y     = pos_y_i;
    wr_entry.w     = (dest_width_i  != '0) ? dest_width_i  : src_width_i;
    wr_entry.h     = (dest_height_i != '0) ? dest_height_i : src_height_i;
    wr_entry.tag   = attr_tag_i;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem[cnt_q[AW-1:0]] <= wr_entry;
    rdata_q <= mem[rd_idx_q];
    ridx_q  <= rd_idx_q;
  end

  // Keep the smallest key not yet emitted; strict compare keeps submit order
  assign take = rd_vld_q && !done_q[ridx_q] &&
                (!best_vld_q || (sort_key(rdata_q) < sort_key(best_q)));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= rdata_q;
      best_idx_q <= ridx_q;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      emit_cnt_q <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      done_q     <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.wr) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.rd) rd_idx_q <= rd_idx_q + 1'b1;
      if (take) best_vld_q <= 1'b1;
      if (cmd_i.emit) begin
        rd_idx_q   <= '0;
        best_vld_q <= 1'b0;
        if (sts_o.emit_last) begin
          cnt_q      <= '0;
          emit_cnt_q <= '0;
          done_q     <= '0;
        end else begin
          emit_cnt_q         <= emit_cnt_q + 1'b1;
          done_q[best_idx_q] <= 1'b1;
        end
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit | cmd_i.drop;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q     <= best_q;
      last_q    <= sts_o.emit_last;
      dropped_q <= 1'b0;
    end else if (cmd_i.drop) begin
      out_q     <= '0;
      last_q    <= 1'b0;
      dropped_q <= 1'b1;
    end
  end

  always_comb begin
    sts_o.full      = (cnt_q == CW'(QUEUE_DEPTH));
    sts_o.empty     = (cnt_q == '0);
    sts_o.rd_last   = (rd_idx_q == AW'(cnt_q - 1'b1));
    sts_o.emit_last = (emit_cnt_q == (cnt_q - 1'b1));
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_q.x;
  assign out_y_o      = out_q.y;
  assign out_width_o  = out_q.w;
  assign out_height_o = out_q.h;
  assign out_tag_o    = out_q.tag;
  assign last_one_o   = last_q;
  assign dropped_o    = dropped_q;

endmodule

// ===== design/depth_sorted_sprite_queue_top.sv =====
// ----------------------------------------------------------------------------
// depth_sorted_sprite_queue_top
// Sprite queue that emits its contents ordered by depth, then layer, then
// submit order, on a flush.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | start_i / busy_o   | opcode_i, sort_depth_i .. attr_tag_i
//  result   | out_valid_o strobe | out_x_o .. out_tag_o, last_one_o, dropped_o
//
//  A submit leaves busy_o low, so submits go back to back;
//  a submit on a full queue gives one dropped beat on the next cycle.
//  A flush runs, for every sprite, one pass over the filled entries through
//  the single read port of the entry memory, then one drain and one emit state.
//  An empty flush leaves the sequencer idle.
//  Reset empties the queue; memory contents are not cleared.
//  Result beats cannot be stalled: each lasts exactly one cycle.
// ----------------------------------------------------------------------------
module depth_sorted_sprite_queue_top import dssq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DSSQ_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      opcode_i,
  input  logic signed [POS_W-1:0]   sort_depth_i,
  input  logic        [LAYER_W-1:0] layer_i,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_y_i,
  input  logic        [SIZE_W-1:0]  dest_width_i,
  input  logic        [SIZE_W-1:0]  dest_height_i,
  input  logic        [SIZE_W-1:0]  src_width_i,
  input  logic        [SIZE_W-1:0]  src_height_i,
  input  logic        [TAG_W-1:0]   attr_tag_i,
  output logic                      out_valid_o,
  output logic signed [POS_W-1:0]   out_x_o,
  output logic signed [POS_W-1:0]   out_y_o,
  output logic        [SIZE_W-1:0]  out_width_o,
  output logic        [SIZE_W-1:0]  out_height_o,
  output logic        [TAG_W-1:0]   out_tag_o,
  output logic                      last_one_o,
  output logic                      dropped_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  dssq_ctl u_ctl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Storage and search
  dssq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sort_depth_i  (sort_depth_i),
    .layer_i       (layer_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .dest_width_i  (dest_width_i),
    .dest_height_i (dest_height_i),
    .src_width_i   (src_width_i),
    .src_height_i  (src_height_i),
    .attr_tag_i    (attr_tag_i),
    .out_valid_o   (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_width_o   (out_width_o),
    .out_height_o  (out_height_o),
    .out_tag_o     (out_tag_o),
    .last_one_o    (last_one_o),
    .dropped_o     (dropped_o)
  );

  // A dropped beat never closes a flush
  a_drop_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> !last_one_o)
    else $error("dropped beat marked last");

  // A flush ends with its last beat
  a_flush_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> out_valid_o && last_one_o)
    else $error("flush ended without last beat");

  // Sorted beats only come out of a running flush
  a_sorted_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dropped_o |-> $past(busy_o))
    else $error("sorted beat outside a flush");

endmodule
